### rtl/core/tlik_pkg.sv
// Shared constants, types and the CORDIC angle table for the two-link IK core.
`timescale 1ns / 1ps

package tlik_pkg;

	localparam int LEN_W       = 15;
	localparam int MARGIN_W    = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 15;
	localparam int ANG_OUT_W   = 16;
	localparam int DIST_W      = 16;

	localparam logic [LEN_W-1:0]    LINK_ONE_RST = 15'd2560;
	localparam logic [LEN_W-1:0]    LINK_TWO_RST = 15'd2048;
	localparam logic [MARGIN_W-1:0] MARGIN_RST   = 8'd1;

	// angles are carried as 32 bit fractions of a turn
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] ARM_LIMIT = 32'hC000_0000;

	localparam int CORDIC_IN_W  = 34;
	localparam int CORDIC_STEPS = 28;
	localparam int NORM_STEPS   = 7;
	localparam int NORM_EXP     = 40;
	localparam int CORDIC_LAT   = 1 + NORM_STEPS + CORDIC_STEPS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINK_ONE = 2'd0,
		REG_LINK_TWO = 2'd1,
		REG_MARGIN   = 2'd2
	} cfg_reg_t;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5
	};

endpackage

### rtl/core/tlik_cordic.sv
// Pipelined vectoring CORDIC: atan2(in_y, in_x) as a 32 bit fraction of a turn.
`timescale 1ns / 1ps

module tlik_cordic import tlik_pkg::*; (
	input  logic                          clk,
	input  logic signed [CORDIC_IN_W-1:0] in_y,
	input  logic signed [CORDIC_IN_W-1:0] in_x,
	output logic [31:0]                   angle
);

	localparam int NW = NORM_EXP + 2;
	localparam int RW = NORM_EXP + 5;

	logic signed [NW-1:0] nx [0:NORM_STEPS];
	logic signed [NW-1:0] ny [0:NORM_STEPS];
	logic [31:0]          nz [0:NORM_STEPS];
	logic                 nzero [0:NORM_STEPS];

	logic signed [RW-1:0] cx [1:CORDIC_STEPS];
	logic signed [RW-1:0] cy [1:CORDIC_STEPS];
	logic [31:0]          cz [1:CORDIC_STEPS];
	logic                 czero [1:CORDIC_STEPS];

	// fold the left half plane onto the right one
	always_ff @(posedge clk) begin
		nzero[0] <= (in_x == '0) && (in_y == '0);
		if (in_x < 0) begin
			nx[0] <= -NW'(in_x);
			ny[0] <= -NW'(in_y);
			nz[0] <= HALF_TURN;
		end else begin
			nx[0] <= NW'(in_x);
			ny[0] <= NW'(in_y);
			nz[0] <= '0;
		end
	end

	// binary search for the doubling count, then one last doubling
	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int SHF = (j < NORM_STEPS - 1) ? (32 >> j) : 1;
		localparam int LIM = (j < NORM_STEPS - 1) ? (NORM_EXP - SHF) : NORM_EXP;
		logic [NW-1:0] ay;
		logic          fits;

		assign ay   = ny[j][NW-1] ? $unsigned(-ny[j]) : $unsigned(ny[j]);
		assign fits = ($unsigned(nx[j]) < (NW'(1) << LIM)) && (ay < (NW'(1) << LIM));

		always_ff @(posedge clk) begin
			nx[j+1]    <= fits ? (nx[j] <<< SHF) : nx[j];
			ny[j+1]    <= fits ? (ny[j] <<< SHF) : ny[j];
			nz[j+1]    <= nz[j];
			nzero[j+1] <= nzero[j];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [RW-1:0] xi;
		logic signed [RW-1:0] yi;
		logic [31:0]          zi;
		logic                 zf;
		logic signed [RW-1:0] xs;
		logic signed [RW-1:0] ys;

		if (i == 0) begin : g_first
			assign xi = RW'(nx[NORM_STEPS]);
			assign yi = RW'(ny[NORM_STEPS]);
			assign zi = nz[NORM_STEPS];
			assign zf = nzero[NORM_STEPS];
		end else begin : g_next
			assign xi = cx[i];
			assign yi = cy[i];
			assign zi = cz[i];
			assign zf = czero[i];
		end

		assign xs = xi >>> i;
		assign ys = yi >>> i;

		always_ff @(posedge clk) begin
			czero[i+1] <= zf;
			if (!yi[RW-1]) begin
				cx[i+1] <= xi + ys;
				cy[i+1] <= yi - xs;
				cz[i+1] <= zi + ATAN_TAB[i];
			end else begin
				cx[i+1] <= xi - ys;
				cy[i+1] <= yi + xs;
				cz[i+1] <= zi - ATAN_TAB[i];
			end
		end
	end

	// a zero vector has direction zero
	assign angle = czero[CORDIC_STEPS] ? '0 : cz[CORDIC_STEPS];

endmodule

### rtl/core/two_link_inverse_kinematics_core.sv
// Top level of the two-link planar arm inverse kinematics pipeline.
//
// channel  | signals                                      | transfer when
// command  | start, busy, target_x, target_y              | start && !busy
// result   | done, shoulder_angle, elbow_angle            | done (one cycle)
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | cfg_valid && cfg_ready
//
// One target enters per cycle; its result shows on done with the angles. The depth
// comes from the distance square root (one bit per stage), the 32-stage cosine square
// roots and the 36-stage CORDIC units.
// Reset clears the valid line and loads the link and margin defaults.
// Nothing stalls: busy stays low and cfg_ready stays high.
`timescale 1ns / 1ps

module two_link_inverse_kinematics_core import tlik_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] target_x,
	input  logic signed [COORD_BITS-1:0] target_y,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	output logic                         done,
	output logic signed [ANG_OUT_W-1:0]  shoulder_angle,
	output logic [ANG_OUT_W-1:0]         elbow_angle
);

	localparam int SQ_W        = 2 * COORD_BITS;
	localparam int DCW         = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
	localparam int ACOS_STEPS  = 32;
	localparam int PROD_W      = 64;
	localparam int C_DLY       = 2 + ACOS_STEPS;
	localparam int THETA_DLY   = COORD_BITS + 8 + ACOS_STEPS;
	localparam int LATENCY     = 9 + COORD_BITS + ACOS_STEPS + CORDIC_LAT + 2;
	localparam int SH          = 32 - ANGLE_BITS;

	logic [LEN_W-1:0]    link_one_q;
	logic [LEN_W-1:0]    link_two_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [2*LEN_W-1:0]  l1sq_q;
	logic [2*LEN_W-1:0]  l2sq_q;
	logic [2*LEN_W-1:0]  l12_q;
	logic [DIST_W-1:0]   lo_q;
	logic signed [DIST_W:0] hi_q;
	logic [LEN_W-1:0]    span;

	logic [LATENCY-1:0]  vld_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_one_q <= LINK_ONE_RST;
			link_two_q <= LINK_TWO_RST;
			margin_q   <= MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_LINK_ONE: link_one_q <= cfg_data[LEN_W-1:0];
				REG_LINK_TWO: link_two_q <= cfg_data[LEN_W-1:0];
				REG_MARGIN:   margin_q   <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// terms that depend on configuration only
	assign span = (link_one_q >= link_two_q) ? (link_one_q - link_two_q)
		: (link_two_q - link_one_q);

	always_ff @(posedge clk) begin
		l1sq_q <= (2*LEN_W)'(link_one_q) * (2*LEN_W)'(link_one_q);
		l2sq_q <= (2*LEN_W)'(link_two_q) * (2*LEN_W)'(link_two_q);
		l12_q  <= (2*LEN_W)'(link_one_q) * (2*LEN_W)'(link_two_q);
		lo_q   <= DIST_W'(span) + DIST_W'(margin_q);
		hi_q   <= $signed((DIST_W+1)'(link_one_q) + (DIST_W+1)'(link_two_q)
			- (DIST_W+1)'(margin_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start && !busy};
		end
	end

	assign done = vld_q[LATENCY-1];

	// target delay line; tap 0 is the input register
	logic signed [COORD_BITS-1:0] tx [0:THETA_DLY];
	logic signed [COORD_BITS-1:0] ty [0:THETA_DLY];

	always_ff @(posedge clk) begin
		tx[0] <= target_x;
		ty[0] <= target_y;
	end

	for (genvar k = 0; k < THETA_DLY; k++) begin : g_tdly
		always_ff @(posedge clk) begin
			tx[k+1] <= tx[k];
			ty[k+1] <= ty[k];
		end
	end

	logic signed [SQ_W-1:0] xx_s2;
	logic signed [SQ_W-1:0] yy_s2;

	always_ff @(posedge clk) begin
		xx_s2 <= tx[0] * tx[0];
		yy_s2 <= ty[0] * ty[0];
	end

	// distance square root, one result bit per stage
	logic [SQ_W:0]         drem  [0:COORD_BITS];
	logic [COORD_BITS-1:0] droot [0:COORD_BITS];

	always_ff @(posedge clk) begin
		drem[0]  <= (SQ_W+1)'($unsigned(xx_s2)) + (SQ_W+1)'($unsigned(yy_s2));
		droot[0] <= '0;
	end

	for (genvar i = 0; i < COORD_BITS; i++) begin : g_dist
		localparam int B = COORD_BITS - 1 - i;
		logic [SQ_W:0] trial;

		assign trial = ((SQ_W+1)'(droot[i]) << (B + 1)) + ((SQ_W+1)'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (drem[i] >= trial) begin
				drem[i+1]  <= drem[i] - trial;
				droot[i+1] <= droot[i] | (COORD_BITS'(1) << B);
			end else begin
				drem[i+1]  <= drem[i];
				droot[i+1] <= droot[i];
			end
		end
	end

	// clamp into the reachable band, never below one LSB
	logic signed [DCW-1:0] dclamp;
	logic [DIST_W-1:0]     d_s4;

	always_comb begin
		dclamp = $signed(DCW'(droot[COORD_BITS]));
		if (dclamp < $signed(DCW'(lo_q))) begin
			dclamp = $signed(DCW'(lo_q));
		end
		if (dclamp > DCW'(hi_q)) begin
			dclamp = DCW'(hi_q);
		end
		if (dclamp < DCW'(1)) begin
			dclamp = DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		d_s4 <= dclamp[DIST_W-1:0];
	end

	logic [31:0] dd_s5;
	logic [30:0] dl_s5;

	always_ff @(posedge clk) begin
		dd_s5 <= 32'(d_s4) * 32'(d_s4);
		dl_s5 <= 31'(d_s4) * 31'(link_one_q);
	end

	// channel 0: inner shoulder angle, channel 1: arm angle
	logic signed [33:0] num_s6 [2];
	logic [31:0]        den_s6 [2];

	always_ff @(posedge clk) begin
		num_s6[0] <= $signed(34'(l1sq_q) + 34'(dd_s5) - 34'(l2sq_q));
		den_s6[0] <= {dl_s5, 1'b0};
		num_s6[1] <= $signed(34'(l1sq_q) + 34'(l2sq_q) - 34'(dd_s5));
		den_s6[1] <= {1'b0, l12_q, 1'b0};
	end

	logic [31:0]        dm_s7  [2];
	logic [32:0]        dp_s7  [2];
	logic [48:0]        ppl_s8 [2];
	logic [47:0]        pph_s8 [2];
	logic signed [32:0] cdl    [2][0:C_DLY];
	logic [PROD_W:0]    arem   [2][0:ACOS_STEPS];
	logic [31:0]        aroot  [2][0:ACOS_STEPS];
	logic [31:0]        z_ang  [3];

	for (genvar ch = 0; ch < 2; ch++) begin : g_chan
		logic [33:0]        mag;
		logic [31:0]        an;
		logic signed [32:0] cv;

		// limit |num| to den so the ratio saturates at +-1
		assign mag = num_s6[ch][33] ? $unsigned(-num_s6[ch]) : $unsigned(num_s6[ch]);
		assign an  = (mag > 34'(den_s6[ch])) ? den_s6[ch] : mag[31:0];
		assign cv  = $signed({1'b0, an});

		always_ff @(posedge clk) begin
			dm_s7[ch]     <= den_s6[ch] - an;
			dp_s7[ch]     <= 33'(den_s6[ch]) + 33'(an);
			cdl[ch][0]    <= num_s6[ch][33] ? -cv : cv;
			ppl_s8[ch]    <= 49'(dm_s7[ch]) * 49'(dp_s7[ch][16:0]);
			pph_s8[ch]    <= 48'(dm_s7[ch]) * 48'(dp_s7[ch][32:17]);
			arem[ch][0]   <= (PROD_W+1)'(ppl_s8[ch]) + ((PROD_W+1)'(pph_s8[ch]) << 17);
			aroot[ch][0]  <= '0;
		end

		for (genvar k = 0; k < C_DLY; k++) begin : g_cdly
			always_ff @(posedge clk) begin
				cdl[ch][k+1] <= cdl[ch][k];
			end
		end

		for (genvar i = 0; i < ACOS_STEPS; i++) begin : g_sqrt
			localparam int B = ACOS_STEPS - 1 - i;
			logic [PROD_W:0] trial;

			assign trial = ((PROD_W+1)'(aroot[ch][i]) << (B + 1))
				+ ((PROD_W+1)'(1) << (2 * B));

			always_ff @(posedge clk) begin
				if (arem[ch][i] >= trial) begin
					arem[ch][i+1]  <= arem[ch][i] - trial;
					aroot[ch][i+1] <= aroot[ch][i] | (32'(1) << B);
				end else begin
					arem[ch][i+1]  <= arem[ch][i];
					aroot[ch][i+1] <= aroot[ch][i];
				end
			end
		end

		tlik_cordic u_acos (
			.clk   (clk),
			.in_y  ($signed(CORDIC_IN_W'(aroot[ch][ACOS_STEPS]))),
			.in_x  (CORDIC_IN_W'(cdl[ch][C_DLY])),
			.angle (z_ang[ch + 1])
		);
	end

	tlik_cordic u_theta (
		.clk   (clk),
		.in_y  (CORDIC_IN_W'(ty[THETA_DLY])),
		.in_x  (CORDIC_IN_W'(tx[THETA_DLY])),
		.angle (z_ang[0])
	);

	logic [31:0] shd_s10;
	logic [31:0] elb_s10;
	logic [31:0] arm_c;
	logic [31:0] shd_r;
	logic [31:0] elb_r;

	// pull CORDIC overshoot back into [0, pi]
	always_comb begin
		arm_c = z_ang[2];
		if (z_ang[2] > ARM_LIMIT) begin
			arm_c = '0;
		end else if (z_ang[2] > HALF_TURN) begin
			arm_c = HALF_TURN;
		end
	end

	always_ff @(posedge clk) begin
		shd_s10 <= z_ang[0] - z_ang[1];
		elb_s10 <= HALF_TURN - arm_c;
	end

	// round half up; the carry out of bit 31 drops with the wrap
	assign shd_r = shd_s10 + (32'(1) << (SH - 1));
	assign elb_r = elb_s10 + (32'(1) << (SH - 1));

	always_ff @(posedge clk) begin
		shoulder_angle <= $signed(ANG_OUT_W'(shd_r[31:SH]));
		elbow_angle    <= ANG_OUT_W'(elb_r[31:SH]);
	end

endmodule

### rtl/core/tlik_checker.sv
// Port-level checks for the two-link IK core, bound onto the top level.
`timescale 1ns / 1ps

module tlik_checker import tlik_pkg::*; #(
	parameter int LATENCY    = 95,
	parameter int ANGLE_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [ANG_OUT_W-1:0] elbow_angle
);

	localparam logic [ANG_OUT_W-1:0] ELBOW_MAX = ANG_OUT_W'(1 << (ANGLE_BITS - 1));

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("transfer without a result after the pipeline delay");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching command transfer");

	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((ANGLE_BITS > ANG_OUT_W) || (elbow_angle <= ELBOW_MAX)))
		else $error("elbow angle beyond a half turn");

endmodule

bind two_link_inverse_kinematics_core tlik_checker #(
	.LATENCY    (LATENCY),
	.ANGLE_BITS (ANGLE_BITS)
) u_tlik_checker (.*);

### tb/tlik_checker.sv
// Checker for the two-link IK core: predicts joint angles per target and compares results.
`timescale 1ns / 1ps

module tlik_scoreboard import tlik_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic signed [15:0]          target_x,
	input  logic signed [15:0]          target_y,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        done,
	input  logic signed [ANG_OUT_W-1:0] shoulder_angle,
	input  logic [ANG_OUT_W-1:0]        elbow_angle,
	output int                          fail_count,
	output int                          angles_pending
);

	localparam longint NORM_LIM = longint'(1) << NORM_EXP;
	localparam longint unsigned TURN_MASK = 64'hFFFF_FFFF;

	typedef struct {
		logic [15:0] shoulder;
		logic [15:0] elbow;
	} joint_angles_t;

	joint_angles_t angle_q[$];
	logic [LEN_W-1:0]    link_one;
	logic [LEN_W-1:0]    link_two;
	logic [MARGIN_W-1:0] margin;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// vectoring CORDIC, result as a 32 bit fraction of a turn
	function automatic longint unsigned turn_atan2(longint y, longint x);
		longint unsigned z;
		longint xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN;
		end
		while (abs64(x) < NORM_LIM && abs64(y) < NORM_LIM) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = (z + ATAN_TAB[i]) & TURN_MASK;
			end else begin
				x = x - ys;
				y = y + xs;
				z = (z - ATAN_TAB[i]) & TURN_MASK;
			end
		end
		return z;
	endfunction

	// saturating acos(num/den) without a division
	function automatic longint unsigned turn_acos(longint num, longint unsigned den);
		longint unsigned an, s;
		longint c;
		an = abs64(num);
		if (an > den)
			an = den;
		s = int_sqrt((den - an) * (den + an));
		c = num < 0 ? -longint'(an) : longint'(an);
		return turn_atan2(longint'(s), c);
	endfunction

	function automatic logic [15:0] round_turn(longint unsigned a);
		return 16'((a + (64'd1 << 15)) >> 16);
	endfunction

	function automatic joint_angles_t solve_joints(longint x, longint y);
		joint_angles_t r;
		longint l1, l2, lo, hi, d;
		longint unsigned theta, hat, arm;
		l1 = link_one;
		l2 = link_two;
		lo = abs64(l1 - l2) + longint'(margin);
		hi = l1 + l2 - longint'(margin);
		d = longint'(int_sqrt(longint'(x * x) + longint'(y * y)));
		if (d < lo) d = lo;
		if (d > hi) d = hi;
		if (d < 1) d = 1;
		theta = turn_atan2(y, x);
		hat = turn_acos(l1 * l1 + d * d - l2 * l2, longint'(2 * d * l1));
		arm = turn_acos(l1 * l1 + l2 * l2 - d * d, longint'(2 * l1 * l2));
		// pull CORDIC overshoot back into [0, pi]
		if (arm > ARM_LIMIT)
			arm = 0;
		else if (arm > HALF_TURN)
			arm = HALF_TURN;
		r.shoulder = round_turn((theta - hat) & TURN_MASK);
		r.elbow = round_turn(HALF_TURN - arm);
		return r;
	endfunction

	assign angles_pending = angle_q.size();

	always @(posedge clk or negedge arst_n) begin
		joint_angles_t exp_a;
		if (!arst_n) begin
			link_one <= LINK_ONE_RST;
			link_two <= LINK_TWO_RST;
			margin <= MARGIN_RST;
			fail_count <= 0;
			angle_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_LINK_ONE: link_one <= cfg_data[LEN_W-1:0];
					REG_LINK_TWO: link_two <= cfg_data[LEN_W-1:0];
					REG_MARGIN:   margin <= cfg_data[MARGIN_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				angle_q.push_back(solve_joints(longint'(target_x), longint'(target_y)));
			if (done) begin
				if (angle_q.size() == 0) begin
					$error("result with no target outstanding");
					fail_count <= fail_count + 1;
				end else begin
					exp_a = angle_q.pop_front();
					if (shoulder_angle !== exp_a.shoulder || elbow_angle !== exp_a.elbow)
						fail_count <= fail_count + 1;
					if (shoulder_angle !== exp_a.shoulder)
						$error("shoulder_angle expected %0h got %0h", exp_a.shoulder,
							shoulder_angle);
					if (elbow_angle !== exp_a.elbow)
						$error("elbow_angle expected %0h got %0h", exp_a.elbow, elbow_angle);
				end
			end
		end
	end

endmodule

### tb/tb_top.sv
// Testbench top for the two-link IK core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top import tlik_pkg::*;;

	localparam int DRAIN_CYCLES = 110;
	localparam int STALL_LIMIT  = 4000;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic signed [15:0]          target_x = '0;
	logic signed [15:0]          target_y = '0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        done;
	logic signed [ANG_OUT_W-1:0] shoulder_angle;
	logic [ANG_OUT_W-1:0]        elbow_angle;
	int                          fail_count;
	int                          angles_pending;
	int                          quiet_cycles;
	int                          reach;
	bit                          no_gaps;

	always #6 clk = ~clk;

	two_link_inverse_kinematics_core DUT (.*);

	tlik_scoreboard checker_i (.*);

	// end the run if nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain the pipeline, then load a new arm geometry
	task automatic set_arm(int unsigned l1, int unsigned l2, int unsigned mg);
		@(posedge clk);
		start <= 1'b0;
		wait (angles_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_LINK_ONE, l1);
		write_reg(REG_LINK_TWO, l2);
		write_reg(REG_MARGIN, mg);
		reach = l1 + l2 + 256;
		if (reach > 32767) reach = 32767;
	endtask

	task automatic send_target(int x, int y);
		int gap;
		if (!no_gaps && $urandom_range(99) < 18) begin
			gap = $urandom_range(1, 3);
			@(posedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(posedge clk);
		end
		@(posedge clk);
		start <= 1'b1;
		target_x <= 16'(x);
		target_y <= 16'(y);
		@(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic random_target();
		int m;
		m = $urandom_range(99);
		if (m < 60)
			send_target($urandom_range(0, 2 * reach) - reach, $urandom_range(0, 2 * reach) - reach);
		else if (m < 70)
			send_target($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32);
		else
			send_target($signed(16'($urandom)), $signed(16'($urandom)));
	endtask

	task automatic corner_targets();
		send_target(0, 0);
		send_target(32767, 32767);
		send_target(-32768, -32768);
		send_target(-32768, 0);
		send_target(0, -32768);
		send_target(1, 0);
		send_target(-1, 0);
		send_target(0, 1);
		send_target(-1, -1);
	endtask

	initial begin
		reach = 4864;
		no_gaps = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// reset geometry first, with points inside, on and past the reach band
		corner_targets();
		send_target(4608, 0);
		send_target(512, 0);
		send_target(0, 4607);
		send_target(-2000, 3000);
		send_target(3000, -2000);
		send_target(-4608, -1);
		// zero link lengths
		set_arm(0, 0, 0);
		corner_targets();
		set_arm(0, 3000, 7);
		send_target(100, 100);
		send_target(-5000, 200);
		// shortest and longest links, margin extremes
		set_arm(1, 1, 0);
		corner_targets();
		set_arm(32767, 32767, 255);
		corner_targets();
		// margin wider than the reach band
		set_arm(100, 120, 255);
		send_target(150, 50);
		send_target(-300, 10);
		set_arm(32767, 1, 0);
		send_target(30000, -20000);
		send_target(-1, 32767);
		for (int ph = 0; ph < 9; ph++) begin
			if (ph % 3 == 0)
				set_arm($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 255));
			else
				set_arm($urandom_range(1, 10000), $urandom_range(1, 10000), $urandom_range(0, 32));
			for (int n = 0; n < 45; n++) begin
				no_gaps = (ph == 4);
				random_target();
			end
		end
		no_gaps = 0;
		set_arm(LINK_ONE_RST, LINK_TWO_RST, MARGIN_RST);
		for (int n = 0; n < 10; n++)
			random_target();
		@(posedge clk);
		start <= 1'b0;
		wait (angles_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && angles_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
